/* rtl/sgo_pkg.sv */
// shared constants, types and tables of the sobel gradient orientation block
package sgo_pkg;

	// frame geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W      = 16;
	localparam int ROW_W      = HGT_W + 1;
	localparam int CFG_WID_W  = 11;

	// pixel and result fields
	localparam int CH_W       = 8;
	localparam int SUM_W      = 10;
	localparam int CSUM_W     = 12;
	localparam int GRAD_W     = 13;
	localparam int MAG_W      = 16;
	localparam int MAG_IW     = $clog2(MAG_W);
	localparam int ANG_W      = 16;

	// magnitude search: m*m*MAG_DIV <= sq << MAG_SHIFT
	localparam int SQ_W       = 25;
	localparam int MAG_SHIFT  = 27;
	localparam int MAG_DIV    = 585225;
	localparam int REM_W      = 54;

	// vectoring cordic
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_N     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int PIPE_N       = (CORDIC_N > MAG_W) ? CORDIC_N : MAG_W;
	localparam int XW           = 30;
	localparam int YW           = 31;
	localparam int ZW           = 26;
	localparam int ATAN_W       = 23;
	localparam int ANG_PRE_W    = 17;
	localparam int Z_MAX        = 8388608;
	localparam int ANG_HALF     = 32768;

	localparam logic [ATAN_W-1:0] ATAN_TAB [24] = '{
		23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
		23'd83436, 23'd41721, 23'd20861, 23'd10430, 23'd5215, 23'd2608,
		23'd1304, 23'd652, 23'd326, 23'd163, 23'd81, 23'd41,
		23'd20, 23'd10, 23'd5, 23'd3, 23'd1, 23'd1
	};

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BORDER = 2'd2;

	localparam logic [CFG_WID_W-1:0] RST_WIDTH  = 11'd640;
	localparam logic [HGT_W-1:0]     RST_HEIGHT = 16'd480;
	localparam logic                 RST_BORDER = 1'b1;

	// effective frame settings seen by the front
	typedef struct packed {
		logic [WCNT_W-1:0] width;
		logic [HGT_W-1:0]  height;
		logic              border;
	} cfg_t;

	// gradient pair queued for the back
	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     last;
	} grad_t;

endpackage

/* rtl/sgo_if.sv */
// channel interfaces: pixel input, result output, configuration writes
interface sgo_pixel_if import sgo_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red_level;
	logic [CH_W-1:0] green_level;
	logic [CH_W-1:0] blue_level;
	logic            flush_item;

	modport source(output valid, red_level, green_level, blue_level, flush_item, input ready);
	modport sink(input valid, red_level, green_level, blue_level, flush_item, output ready);
endinterface

interface sgo_result_if import sgo_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] x_gradient;
	logic signed [GRAD_W-1:0] y_gradient;
	logic [MAG_W-1:0]         edge_magnitude;
	logic [ANG_W-1:0]         edge_angle;
	logic                     frame_last;

	modport source(output valid, x_gradient, y_gradient, edge_magnitude, edge_angle,
		frame_last, input ready);
	modport sink(input valid, x_gradient, y_gradient, edge_magnitude, edge_angle,
		frame_last, output ready);
endinterface

interface sgo_cfg_if import sgo_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/sgo_front.sv */
// front: raster counters, line stores, 3x3 window and sobel sums
module sgo_front import sgo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        clr,
	sgo_pixel_if.sink   pixel,
	output logic        push_valid,
	output grad_t       push_data,
	input  logic        push_ready
);

	typedef struct packed {
		logic res;
		logic last;
		logic top_out;
		logic bot_out;
		logic left_out;
		logic right_out;
	} pos_t;

	logic [ADDR_W-1:0] c_q, c_n, col;
	logic [ROW_W-1:0]  r_q, r_n, r_inc, h_ext;
	logic [WCNT_W-1:0] col_inc;
	logic              first_col, res_end, res_mid;
	pos_t              pos;
	logic [SUM_W-1:0]  sum;
	logic              acc, adv;

	logic              v_s1;
	pos_t              pos_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [SUM_W-1:0]  s_s1, top_s1, mid_s1;

	logic [SUM_W-1:0]  upper_mem [MAX_WIDTH];
	logic [SUM_W-1:0]  middle_mem [MAX_WIDTH];
	logic [SUM_W-1:0]  win_a_q [3];
	logic [SUM_W-1:0]  win_b_q [3];

	logic [SUM_W-1:0]  cl [3][3];
	logic [CSUM_W-1:0] left_sum, right_sum, upper_sum, lower_sum;

	// handshake
	assign adv         = v_s1 && (!pos_s1.res || push_ready);
	assign pixel.ready = !v_s1 || adv;
	assign acc         = pixel.valid && pixel.ready;
	assign push_valid  = v_s1 && pos_s1.res;

	// position of the incoming beat and what it completes
	always_comb begin
		h_ext     = ROW_W'(cfg.height);
		col       = (WCNT_W'(c_q) >= cfg.width) ? '0 : c_q;
		first_col = (col == '0);
		res_end   = first_col && (r_q >= ROW_W'(2));
		res_mid   = !first_col && (r_q != '0) && (r_q <= h_ext);
		pos.res   = res_end || res_mid;
		pos.last  = res_end && (r_q == h_ext + ROW_W'(1));
		pos.top_out   = res_end ? (r_q == ROW_W'(2)) : (r_q == ROW_W'(1));
		pos.bot_out   = res_end ? (r_q >= h_ext + ROW_W'(1)) : (r_q >= h_ext);
		pos.left_out  = res_end ? (cfg.width == WCNT_W'(1)) : (col == ADDR_W'(1));
		pos.right_out = res_end;
		col_inc = WCNT_W'(col) + WCNT_W'(1);
		r_inc   = r_q + ROW_W'(1);
		if (r_inc > h_ext + ROW_W'(1)) begin
			r_inc = h_ext + ROW_W'(1);
		end
		if (pos.last) begin
			c_n = '0;
			r_n = '0;
		end else if (col_inc >= cfg.width) begin
			c_n = '0;
			r_n = r_inc;
		end else begin
			c_n = ADDR_W'(col_inc);
			r_n = r_q;
		end
		sum = pixel.flush_item ? '0 : SUM_W'(pixel.red_level) + SUM_W'(pixel.green_level)
			+ SUM_W'(pixel.blue_level);
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (clr) begin
			c_q <= '0;
			r_q <= '0;
		end else if (acc) begin
			c_q <= c_n;
			r_q <= r_n;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pos_s1  <= pos;
			addr_s1 <= col;
			s_s1    <= sum;
		end
	end

	// line stores, with forwarding of the write in flight
	always_ff @(posedge clk) begin
		if (adv) begin
			upper_mem[addr_s1]  <= mid_s1;
			middle_mem[addr_s1] <= s_s1;
		end
		if (acc) begin
			if (adv && (addr_s1 == col)) begin
				top_s1 <= mid_s1;
				mid_s1 <= s_s1;
			end else begin
				top_s1 <= upper_mem[col];
				mid_s1 <= middle_mem[col];
			end
		end
	end

	// window columns left of the incoming one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_a_q[i] <= '0;
				win_b_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < 3; i++) begin
				win_a_q[i] <= win_b_q[i];
			end
			win_b_q[0] <= top_s1;
			win_b_q[1] <= mid_s1;
			win_b_q[2] <= s_s1;
		end
	end

	// border handling: rows first, then columns
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cl[0][i] = win_a_q[i];
			cl[1][i] = win_b_q[i];
		end
		cl[2][0] = top_s1;
		cl[2][1] = mid_s1;
		cl[2][2] = s_s1;
		for (int c = 0; c < 3; c++) begin
			if (pos_s1.top_out) cl[c][0] = cfg.border ? cl[c][1] : '0;
			if (pos_s1.bot_out) cl[c][2] = cfg.border ? cl[c][1] : '0;
		end
		for (int i = 0; i < 3; i++) begin
			if (pos_s1.left_out)  cl[0][i] = cfg.border ? cl[1][i] : '0;
			if (pos_s1.right_out) cl[2][i] = cfg.border ? cl[1][i] : '0;
		end
	end

	// sobel sums
	always_comb begin
		left_sum  = CSUM_W'(cl[0][0]) + (CSUM_W'(cl[0][1]) << 1) + CSUM_W'(cl[0][2]);
		right_sum = CSUM_W'(cl[2][0]) + (CSUM_W'(cl[2][1]) << 1) + CSUM_W'(cl[2][2]);
		upper_sum = CSUM_W'(cl[0][0]) + (CSUM_W'(cl[1][0]) << 1) + CSUM_W'(cl[2][0]);
		lower_sum = CSUM_W'(cl[0][2]) + (CSUM_W'(cl[1][2]) << 1) + CSUM_W'(cl[2][2]);
		push_data.gx   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
		push_data.gy   = $signed({1'b0, upper_sum}) - $signed({1'b0, lower_sum});
		push_data.last = pos_s1.last;
	end

endmodule

/* rtl/sgo_queue.sv */
// small register queue of gradient pairs between front and back
module sgo_queue import sgo_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  grad_t push_data,
	output logic  push_ready,
	input  logic  pop,
	output logic  pop_valid,
	output grad_t pop_data
);

	grad_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               do_push, do_pop;

	assign push_ready = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + FIFO_AW'(1);
			if (do_pop)  rd_q <= rd_q + FIFO_AW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (FIFO_AW+1)'(1);
		end
	end

endmodule

/* rtl/sgo_back.sv */
// back: pipelined magnitude search and vectoring cordic, output register
module sgo_back import sgo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	input  grad_t       pop_data,
	output logic        pop,
	sgo_result_if.source result
);

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [REM_W-1:0]     prd;
		logic [MAG_W-1:0]     mag;
		logic [XW-1:0]        x;
		logic signed [YW-1:0] y;
		logic signed [ZW-1:0] z;
		grad_t                g;
		logic                 gxz;
		logic                 gyz;
		logic                 neg;
	} st_t;

	logic                 en;
	logic                 v_p0;
	grad_t                g_p0;
	logic [CSUM_W-1:0]    ax, ay;
	logic [2*CSUM_W-1:0]  ax2, ay2;
	st_t                  init;
	st_t                  st_s [PIPE_N+1];
	logic                 v_s [PIPE_N+1];
	st_t                  fin;
	logic signed [ZW-1:0] zc;
	logic [ANG_PRE_W-1:0] a_pre, a_neg;
	logic [ANG_W-1:0]     ang;

	// one magnitude bit and one rotation per stage
	function automatic st_t stage_step(st_t s, int k);
		st_t              o;
		int               b;
		logic [REM_W-1:0] dlt;
		logic [YW-1:0]    ya;
		logic [XW-1:0]    xs;
		o = s;
		if (k < MAG_W) begin
			b   = MAG_W - 1 - k;
			dlt = ((s.prd << 1) + (REM_W'(MAG_DIV) << b)) << b;
			if (dlt <= s.rem) begin
				o.rem = s.rem - dlt;
				o.prd = s.prd + (REM_W'(MAG_DIV) << b);
				o.mag[MAG_IW'(b)] = 1'b1;
			end
		end
		if (k < CORDIC_N) begin
			ya = s.y[YW-1] ? YW'(-s.y) : YW'(s.y);
			xs = s.x >> k;
			o.x = s.x + XW'(ya >> k);
			if (!s.y[YW-1]) begin
				o.y = s.y - $signed(YW'(xs));
				o.z = s.z + $signed(ZW'(ATAN_TAB[5'(k)]));
			end else begin
				o.y = s.y + $signed(YW'(xs));
				o.z = s.z - $signed(ZW'(ATAN_TAB[5'(k)]));
			end
		end
		return o;
	endfunction

	assign en  = !result.valid || result.ready;
	assign pop = en && pop_valid;

	// beat taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p0 <= 1'b0;
		end else if (en) begin
			v_p0 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_p0 <= pop_data;
		end
	end

	// squares and cordic start vector
	always_comb begin
		ax  = g_p0.gx[GRAD_W-1] ? CSUM_W'(-g_p0.gx) : CSUM_W'(g_p0.gx);
		ay  = g_p0.gy[GRAD_W-1] ? CSUM_W'(-g_p0.gy) : CSUM_W'(g_p0.gy);
		ax2 = ax * ax;
		ay2 = ay * ay;
		init.rem = REM_W'(SQ_W'(ax2) + SQ_W'(ay2)) << MAG_SHIFT;
		init.prd = '0;
		init.mag = '0;
		init.x   = XW'(ax) << 16;
		init.y   = $signed(YW'(ay) << 16);
		init.z   = '0;
		init.g   = g_p0;
		init.gxz = (g_p0.gx == '0);
		init.gyz = (g_p0.gy == '0);
		init.neg = g_p0.gx[GRAD_W-1] ^ g_p0.gy[GRAD_W-1];
	end

	// iteration stages
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= init;
			for (int k = 0; k < PIPE_N; k++) begin
				st_s[k+1] <= stage_step(st_s[k], k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= PIPE_N; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= v_p0;
			for (int k = 0; k < PIPE_N; k++) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	// angle folding into [0, pi)
	always_comb begin
		fin   = st_s[PIPE_N];
		zc    = fin.z;
		if (zc < 0) zc = '0;
		if (zc > ZW'(Z_MAX)) zc = ZW'(Z_MAX);
		a_pre = ANG_PRE_W'((zc + ZW'(128)) >>> 8);
		a_neg = ANG_PRE_W'(2 * ANG_HALF) - a_pre;
		if (fin.gxz) begin
			ang = fin.gyz ? '0 : ANG_W'(ANG_HALF);
		end else if (fin.gyz) begin
			ang = '0;
		end else if (fin.neg) begin
			ang = a_neg[ANG_PRE_W-1] ? '1 : ANG_W'(a_neg);
		end else begin
			ang = ANG_W'(a_pre);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (en) begin
			result.valid <= v_s[PIPE_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.x_gradient     <= fin.g.gx;
			result.y_gradient     <= fin.g.gy;
			result.edge_magnitude <= fin.mag;
			result.edge_angle     <= ang;
			result.frame_last     <= fin.g.last;
		end
	end

endmodule

/* rtl/sobel_gradient_orientation.sv */
// top level: configuration registers, front, queue and back
// Throughput: one pixel beat per cycle while the result side takes results.
// A result leaves after the beat that completes its window passes the front stage,
// queue, pop register, one square stage, 16 cordic/magnitude stages and output.
// Each result belongs to the pixel width+1 beats earlier in raster order.
// Reset clears counters, window, queue and pipeline valids; the line stores
// are not cleared and need no clearing pass.
module sobel_gradient_orientation import sgo_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sgo_pixel_if.sink     pixel,
	sgo_result_if.source  result,
	sgo_cfg_if.sink       cfg
);

	logic [CFG_WID_W-1:0] width_q;
	logic [HGT_W-1:0]     height_q;
	logic                 border_q;
	logic                 wr, clr;
	cfg_t                 cfg_eff;
	logic                 push_valid, push_ready, pop, pop_valid;
	grad_t                push_data, pop_data;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign clr       = wr && ((cfg.index == CFG_WIDTH) || (cfg.index == CFG_HEIGHT));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			border_q <= RST_BORDER;
		end else if (wr) begin
			case (cfg.index)
				CFG_WIDTH:  width_q  <= cfg.data[CFG_WID_W-1:0];
				CFG_HEIGHT: height_q <= cfg.data[HGT_W-1:0];
				CFG_BORDER: border_q <= cfg.data[0];
				default:    ;
			endcase
		end
	end

	// effective geometry
	always_comb begin
		if (width_q == '0) begin
			cfg_eff.width = WCNT_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			cfg_eff.width = WCNT_W'(MAX_WIDTH);
		end else begin
			cfg_eff.width = WCNT_W'(width_q);
		end
		cfg_eff.height = (height_q == '0) ? HGT_W'(1) : height_q;
		cfg_eff.border = border_q;
	end

	sgo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_eff),
		.clr        (clr),
		.pixel      (pixel),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	sgo_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	sgo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.result    (result)
	);

endmodule

/* rtl/sgo_checker.sv */
// port-level checks of the result channel, bound to the top level
module sgo_checker import sgo_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [GRAD_W-1:0] x_gradient,
	input logic signed [GRAD_W-1:0] y_gradient,
	input logic [MAG_W-1:0]         edge_magnitude,
	input logic [ANG_W-1:0]         edge_angle
);

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its x gradient, magnitude and angle
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(x_gradient) && $stable(edge_angle)
			&& $stable(edge_magnitude))
		else $error("result beat changed while stalled");

	// flat neighborhood gives no edge at all
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (x_gradient == '0) && (y_gradient == '0)
			|-> (edge_angle == '0) && (edge_magnitude == '0))
		else $error("flat neighborhood gives an edge");

	// purely vertical gradient points at a quarter turn
	a_vert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (x_gradient == '0) && (y_gradient != '0)
			|-> (edge_angle == ANG_W'(ANG_HALF)))
		else $error("vertical gradient angle wrong");

	// purely horizontal gradient points at zero
	a_horz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (y_gradient == '0) && (x_gradient != '0) |-> (edge_angle == '0))
		else $error("horizontal gradient angle wrong");

endmodule

bind sobel_gradient_orientation sgo_checker u_sgo_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.x_gradient     (result.x_gradient),
	.y_gradient     (result.y_gradient),
	.edge_magnitude (result.edge_magnitude),
	.edge_angle     (result.edge_angle)
);
